### src/tli_pkg.sv
// Package for the table linear interpolator: payload structs, status codes
// and register indexes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tli_pkg;
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_NOPAIR = 2'd2;

    localparam logic [0:0] REG_LENGTH = 1'd0;
    localparam logic [0:0] REG_TOL    = 1'd1;

    typedef struct packed {
        logic               opcode;
        logic [7:0]         load_index;
        logic [31:0]        point_x;
        logic signed [31:0] point_y;
        logic [31:0]        query_x;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] y_value;
        logic [1:0]         status;
    } out_item_t;
endpackage
`default_nettype wire

### src/tli_front.sv
// Front part: accepts beats, writes loads straight into the table and
// queues queries in a short FIFO. Depends on tli_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tli_front
    import tli_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int IDX_W = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire in_item_t         in_data,
    output logic                  wr_en,
    output logic [IDX_W-1:0]      wr_idx,
    output logic [31:0]           wr_x,
    output logic [31:0]           wr_y,
    output logic                  q_valid,
    output logic [31:0]           q_x,
    input  wire logic             q_take,
    input  wire logic             back_busy
);
    logic [31:0] fifo_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    logic        acc, push;

    // A load may not overtake a queued query, so loads wait until the queue
    // and the back part are empty.
    assign in_stall = (in_data.opcode == OP_LOAD) ? (cnt_reg != 2'd0 || back_busy)
                                                  : (cnt_reg == 2'd2);
    assign acc  = in_valid && !in_stall;
    assign push = acc && in_data.opcode == OP_QUERY;
    assign wr_en  = acc && in_data.opcode == OP_LOAD && {24'd0, in_data.load_index} < 32'(DEPTH);
    assign wr_idx = IDX_W'(in_data.load_index);
    assign wr_x = in_data.point_x;
    assign wr_y = in_data.point_y;
    assign q_valid = cnt_reg != 2'd0;
    assign q_x = fifo_reg[rp_reg];

    always_ff @(posedge clk) begin
        if (push) fifo_reg[wp_reg] <= in_data.query_x;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (q_take) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_take);
        end
    end
endmodule
`default_nettype wire

### src/tli_back.sv
// Back part: holds the table memory, scans for the usable end, checks the
// endpoints, binary searches and divides. Depends on tli_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tli_back
    import tli_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int IDX_W = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_idx,
    input  wire logic [31:0]      wr_x,
    input  wire logic [31:0]      wr_y,
    input  wire logic [8:0]       table_length,
    input  wire logic [4:0]       tolerance_shift,
    input  wire logic             q_valid,
    input  wire logic [31:0]      q_x,
    output logic                  q_take,
    output logic                  busy,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output out_item_t             out_data
);
    localparam int CW = IDX_W + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN, S_E0, S_E1, S_LAST, S_SRCH_RD, S_SRCH,
        S_LO, S_HI, S_PREP, S_DIV, S_FIN, S_OUT
    } state_t;

    logic [31:0] xmem [DEPTH];
    logic [31:0] ymem [DEPTH];
    logic [IDX_W-1:0] raddr;
    logic [31:0] rx_reg, ry_reg;

    state_t      state_reg;
    logic [31:0] q_reg;
    logic [CW-1:0] n_reg, i_reg, last_reg, lo_reg, hi_reg;
    logic [31:0] prevx_reg, x0_reg, y0_reg, xl_reg, yl_reg;
    logic [63:0] rem_reg;
    logic [63:0] num_reg;
    logic [31:0] dx_reg, dy_reg;
    logic [63:0] quo_reg;
    logic [6:0]  bit_reg;
    logic        neg_reg;
    out_item_t   res_reg;

    always_ff @(posedge clk) begin
        if (wr_en)
        begin
            xmem[wr_idx] <= wr_x;
            ymem[wr_idx] <= wr_y;
        end
        rx_reg <= xmem[raddr];
        ry_reg <= ymem[raddr];
    end

    logic [CW-1:0] mid;
    assign mid = CW'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);

    always_comb begin
        unique case (state_reg)
            S_SRCH_RD: raddr = mid[IDX_W-1:0];
            S_LO:      raddr = lo_reg[IDX_W-1:0];
            S_HI:      raddr = hi_reg[IDX_W-1:0];
            S_E1:      raddr = last_reg[IDX_W-1:0];
            default:   raddr = i_reg[IDX_W-1:0];
        endcase
    end

    function automatic logic near(input logic [31:0] q, input logic [31:0] xe,
                                  input logic [4:0] sh);
        logic [31:0] d;
        d = (q >= xe) ? q - xe : xe - q;
        return d <= (xe >> sh);
    endfunction

    logic [CW-1:0] nclamp;
    always_comb begin
        if (table_length < 9'd2) nclamp = CW'(2);
        else if ({23'd0, table_length} > 32'(DEPTH)) nclamp = CW'(DEPTH);
        else nclamp = CW'(table_length);
    end

    logic [64:0] trial;
    assign trial = {rem_reg, num_reg[63]} - {33'd0, dx_reg};

    assign q_take = state_reg == S_IDLE && q_valid;
    assign busy = state_reg != S_IDLE;
    assign out_valid = state_reg == S_OUT;
    assign out_data = res_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE: if (q_valid)
                begin
                    q_reg <= q_x; n_reg <= nclamp; i_reg <= '0;
                    last_reg <= nclamp - CW'(1);
                    state_reg <= S_SCAN_RD;
                end
                S_SCAN_RD: begin
                    i_reg <= i_reg + CW'(1);
                    state_reg <= S_SCAN;
                end
                // rx_reg holds entry i-1; data for entry i arrives next cycle.
                S_SCAN: begin
                    if (i_reg == CW'(1)) x0_reg <= rx_reg;
                    if (i_reg == CW'(1)) y0_reg <= ry_reg;
                    if (i_reg != CW'(1) && prevx_reg >= rx_reg)
                    begin
                        last_reg <= i_reg - CW'(2);
                        state_reg <= S_E0;
                    end
                    else if (i_reg == n_reg)
                        state_reg <= S_E0;
                    else
                    begin
                        prevx_reg <= rx_reg;
                        i_reg <= i_reg + CW'(1);
                    end
                end
                S_E0: begin
                    if (near(q_reg, x0_reg, tolerance_shift))
                    begin
                        res_reg <= '{y_value: y0_reg, status: ST_OK};
                        state_reg <= S_OUT;
                    end
                    else state_reg <= S_E1;
                end
                S_E1: state_reg <= S_LAST;
                S_LAST: begin
                    if (near(q_reg, rx_reg, tolerance_shift))
                    begin
                        res_reg <= '{y_value: ry_reg, status: ST_OK};
                        state_reg <= S_OUT;
                    end
                    else if (q_reg < x0_reg || q_reg > rx_reg || last_reg == '0)
                    begin
                        res_reg <= '{y_value: '0, status: ST_RANGE};
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        lo_reg <= '0; hi_reg <= last_reg;
                        state_reg <= (last_reg > CW'(1)) ? S_SRCH_RD : S_LO;
                    end
                end
                S_SRCH_RD: begin
                    i_reg <= mid;
                    state_reg <= S_SRCH;
                end
                S_SRCH: begin
                    if (q_reg > rx_reg) lo_reg <= i_reg; else hi_reg <= i_reg;
                    if (((q_reg > rx_reg) ? hi_reg - i_reg : i_reg - lo_reg) > CW'(1))
                        state_reg <= S_SRCH_RD;
                    else state_reg <= S_LO;
                end
                S_LO: state_reg <= S_HI;
                S_HI: begin
                    xl_reg <= rx_reg; yl_reg <= ry_reg;
                    state_reg <= S_PREP;
                end
                S_PREP: begin
                    if (!(xl_reg <= q_reg && q_reg <= rx_reg) || rx_reg <= xl_reg)
                    begin
                        res_reg <= '{y_value: '0, status: ST_NOPAIR};
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        dx_reg <= rx_reg - xl_reg;
                        neg_reg <= $signed(ry_reg) < $signed(yl_reg);
                        dy_reg <= ($signed(ry_reg) < $signed(yl_reg)) ?
                                  yl_reg - ry_reg : ry_reg - yl_reg;
                        num_reg <= {32'd0, q_reg - xl_reg};
                        state_reg <= S_FIN;
                        bit_reg <= 7'd0;
                    end
                end
                // Product formed here, then restoring divide one bit a cycle.
                S_FIN: begin
                    num_reg <= {32'd0, num_reg[31:0]} * {32'd0, dy_reg};
                    rem_reg <= '0; quo_reg <= '0;
                    bit_reg <= 7'd64;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (bit_reg == 7'd0)
                    begin
                        res_reg <= '{y_value: neg_reg ? yl_reg - quo_reg[31:0]
                                                      : yl_reg + quo_reg[31:0],
                                     status: ST_OK};
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        num_reg <= {num_reg[62:0], 1'b0};
                        if (!trial[64])
                        begin
                            rem_reg <= trial[63:0];
                            quo_reg <= {quo_reg[62:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= {rem_reg[62:0], num_reg[63]};
                            quo_reg <= {quo_reg[62:0], 1'b0};
                        end
                        bit_reg <= bit_reg - 7'd1;
                    end
                end
                S_OUT: if (!out_stall) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### src/table_linear_interpolator_top.sv
// Top level of the table linear interpolator: register port, front and back.
// Loads are written straight into the table memory. Query time is set by the serial
// end scan over the table memory port, the binary search and the 64-step divider.
// One query at a time in the back part; two queries queue in the front.
// Reset: rst_n asynchronous, active low; registers take table_length 2 and
// tolerance_shift 20; table contents are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module table_linear_interpolator_top
    import tli_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_item_t        out_data
);
    localparam int IDX_W = $clog2(TABLE_DEPTH);

    logic [8:0] len_reg;
    logic [4:0] tol_reg;
    logic wr_en, q_valid, q_take, back_busy;
    logic [IDX_W-1:0] wr_idx;
    logic [31:0] wr_x, wr_y, q_x;

    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[2])
            REG_LENGTH: prdata = {23'd0, len_reg};
            default:    prdata = {27'd0, tol_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            len_reg <= 9'd2;
            tol_reg <= 5'd20;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'd0)
        begin
            if (paddr[2] == REG_LENGTH) len_reg <= pwdata[8:0];
            else tol_reg <= pwdata[4:0];
        end
    end

    tli_front #(.DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_front (
        .clk, .rst_n, .in_valid, .in_stall, .in_data,
        .wr_en, .wr_idx, .wr_x, .wr_y, .q_valid, .q_x, .q_take, .back_busy
    );

    tli_back #(.DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_back (
        .clk, .rst_n, .wr_en, .wr_idx, .wr_x, .wr_y,
        .table_length(len_reg), .tolerance_shift(tol_reg),
        .q_valid, .q_x, .q_take, .busy(back_busy), .out_valid, .out_stall, .out_data
    );
endmodule
`default_nettype wire
